// File: rtl/lcrs_pkg.sv
`default_nettype none

package lcrs_pkg;

  // Node table size and widths, fixed by the 8-bit node and 9-bit link fields.
  localparam int NODES = 256;
  localparam int NAW = 8;
  localparam int LW = 9;
  localparam int LVW = 8;
  localparam logic [LW-1:0] LINK_NONE = 9'd256;
  localparam logic [LVW-1:0] LEVEL_MAX = 8'hFF;

  // Command codes of an input item.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;

  // Sequencer step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_POP = 3'd1;
  localparam logic [STEP_W-1:0] ST_GATHER = 3'd2;
  localparam logic [STEP_W-1:0] ST_PREP = 3'd3;
  localparam logic [STEP_W-1:0] ST_PUSH = 3'd4;

  // Jump condition codes.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd0;
  localparam logic [COND_W-1:0] C_POP = 3'd1;
  localparam logic [COND_W-1:0] C_CHAIN = 3'd2;
  localparam logic [COND_W-1:0] C_PREP = 3'd3;
  localparam logic [COND_W-1:0] C_MORE = 3'd4;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [NAW-1:0] node;
    logic [LW-1:0] kid_link;
    logic [LW-1:0] sib_link;
  } in_item_t;

  typedef struct packed {
    logic           found;
    logic [NAW-1:0] visited;
    logic [LVW-1:0] depth;
  } out_item_t;

  typedef struct packed {
    logic [LW-1:0] child;
    logic [LW-1:0] sibling;
  } link_ent_t;

  typedef struct packed {
    logic [NAW-1:0] node;
    logic [LVW-1:0] level;
  } stk_ent_t;

  // One control word per sequencer step.
  typedef struct packed {
    logic              dispatch;
    logic              emit;
    logic              gather;
    logic              pop_buf;
    logic              push;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ucw_t;

  // Microcode store: actions, jump condition, taken target, fall-through target.
  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.dispatch = 1'b1;
        w.cond = C_POP;
        w.tgt_t = ST_POP;
        w.tgt_f = ST_IDLE;
      end
      ST_POP: begin
        w.emit = 1'b1;
        w.cond = C_ALWAYS;
        w.tgt_t = ST_GATHER;
        w.tgt_f = ST_GATHER;
      end
      ST_GATHER: begin
        w.gather = 1'b1;
        w.cond = C_CHAIN;
        w.tgt_t = ST_GATHER;
        w.tgt_f = ST_PREP;
      end
      ST_PREP: begin
        w.pop_buf = 1'b1;
        w.cond = C_PREP;
        w.tgt_t = ST_PUSH;
        w.tgt_f = ST_IDLE;
      end
      ST_PUSH: begin
        w.pop_buf = 1'b1;
        w.push = 1'b1;
        w.cond = C_MORE;
        w.tgt_t = ST_PUSH;
        w.tgt_f = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lcrs_tree_dfs_iterator.sv
`default_nettype none

// Preorder walker over a left-child right-sibling tree of up to 256 nodes.
// Write items (cmd 0) and start items (cmd 1) give no result. A next item
// (cmd 2) on an empty stack gives a not-found result in the cycle after it
// is accepted, and busy stays low. A next item that pops a node reads it
// through the stack's registered read port, registers its result in the pop
// step and keeps busy high while it gathers the node's children (at most
// MAX_CHILDREN) and pushes them: the sibling chain is followed one link per
// cycle through the registered read port of the link table, then the
// gathered children are pushed one per cycle from the child buffer's read
// port until the buffer is empty or the stack fills. Results are strobed
// on out_valid for one cycle and cannot be held off, so capture them as they
// come. Write node_count only while busy is low and no result is pending.
module lcrs_tree_dfs_iterator #(
  parameter int STACK_DEPTH = 256,
  parameter int MAX_CHILDREN = 256
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire lcrs_pkg::in_item_t in_item,
  output logic                 out_valid,
  output lcrs_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire [8:0]            cfg_wdata
);

  import lcrs_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int BAW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CW = $clog2(MAX_CHILDREN + 1);

  logic [STEP_W-1:0] upc_r, upc_nxt;
  ucw_t              ucw;
  logic              cond_ok;
  logic              accept;
  logic              root_ok;
  logic              do_start;
  logic              do_next;

  logic [8:0]        node_count_r;
  logic [TW-1:0]     top_r, top_nxt;
  logic [TW-1:0]     top_m1;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     cnt_m1;
  logic [LVW-1:0]    lvl_r;
  logic              first_r;
  logic [LW-1:0]     chain_link;

  link_ent_t         link_mem [NODES];
  link_ent_t         link_rd_r;
  logic [NAW-1:0]    link_raddr;

  stk_ent_t          stk_mem [STACK_DEPTH];
  stk_ent_t          stk_rd_r;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  stk_ent_t          stk_wdata;
  logic [SAW-1:0]    stk_raddr;

  logic [NAW-1:0]    buf_mem [MAX_CHILDREN];
  logic [NAW-1:0]    buf_rd_r;
  logic [BAW-1:0]    buf_raddr;

  logic              out_valid_r;
  out_item_t         out_r;

  // Fetch the control word of the current step and decode the item.
  assign ucw = ucode_rom(upc_r);
  assign busy = (upc_r != ST_IDLE);
  assign accept = start && !busy;
  assign root_ok = ({1'b0, in_item.node} < node_count_r);
  assign do_start = ucw.dispatch && accept && (in_item.cmd == CMD_START);
  assign do_next = ucw.dispatch && accept && (in_item.cmd == CMD_NEXT);

  // The first gather cycle follows the child link, the rest follow siblings.
  assign chain_link = first_r ? link_rd_r.child : link_rd_r.sibling;

  // Jump condition and next step address.
  always_comb begin
    case (ucw.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_POP:    cond_ok = do_next && (top_r != '0);
      C_CHAIN:  cond_ok = (chain_link < LINK_NONE) && (cnt_r != CW'(MAX_CHILDREN));
      C_PREP:   cond_ok = (cnt_r != '0) && (top_r != TW'(STACK_DEPTH));
      C_MORE:   cond_ok = (cnt_r != '0) && (top_r != TW'(STACK_DEPTH - 1));
      default:  cond_ok = 1'b0;
    endcase
    upc_nxt = cond_ok ? ucw.tgt_t : ucw.tgt_f;
  end

  // Stack pointer and child counter updates.
  assign top_m1 = top_r - TW'(1);
  assign cnt_m1 = cnt_r - CW'(1);

  always_comb begin
    top_nxt = top_r;
    cnt_nxt = cnt_r;
    if (do_start) begin
      top_nxt = root_ok ? TW'(1) : '0;
    end
    if (do_next && (top_r != '0)) begin
      top_nxt = top_m1;
    end
    if (ucw.push) begin
      top_nxt = top_r + TW'(1);
    end
    if (ucw.emit) begin
      cnt_nxt = '0;
    end
    if (ucw.gather && cond_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (ucw.pop_buf && cond_ok) begin
      cnt_nxt = cnt_m1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
      top_r <= '0;
      node_count_r <= 9'd256;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      top_r <= top_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      out_valid_r <= (do_next && (top_r == '0)) || ucw.emit;
    end
  end

  // Datapath registers: counter, level of the children, gather flag, result.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (ucw.emit) begin
      lvl_r <= (stk_rd_r.level == LEVEL_MAX) ? LEVEL_MAX : stk_rd_r.level + LVW'(1);
      first_r <= 1'b1;
      out_r.found <= 1'b1;
      out_r.visited <= stk_rd_r.node;
      out_r.depth <= stk_rd_r.level;
    end else if (do_next) begin
      out_r <= '0;
    end
    if (ucw.gather) begin
      first_r <= 1'b0;
    end
  end

  // Link table: written by write items, read along the child/sibling chain.
  assign link_raddr = ucw.gather ? chain_link[NAW-1:0] : stk_rd_r.node;

  always_ff @(posedge clk) begin
    if (ucw.dispatch && accept && (in_item.cmd == CMD_WRITE)) begin
      link_mem[in_item.node] <= '{child: in_item.kid_link,
                                  sibling: in_item.sib_link};
    end
    link_rd_r <= link_mem[link_raddr];
  end

  // Node stack: root written by a start item, children pushed by the sequencer.
  assign stk_we = do_start && root_ok || ucw.push;
  assign stk_waddr = ucw.push ? top_r[SAW-1:0] : '0;
  assign stk_wdata = ucw.push ? stk_ent_t'{node: buf_rd_r, level: lvl_r}
                              : stk_ent_t'{node: in_item.node, level: '0};
  assign stk_raddr = top_m1[SAW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // Child buffer: filled in chain order, read back last entry first.
  assign buf_raddr = cnt_m1[BAW-1:0];

  always_ff @(posedge clk) begin
    if (ucw.gather && cond_ok) begin
      buf_mem[cnt_r[BAW-1:0]] <= chain_link[NAW-1:0];
    end
    buf_rd_r <= buf_mem[buf_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // A result only follows a pop step or a next item on an empty stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(upc_r == ST_POP) || $past(do_next && (top_r == '0)))
    else $error("result strobe without a pop or an empty next item");

  // A found result always comes from the pop step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |-> $past(upc_r == ST_POP))
    else $error("found result outside the pop step");

  // The stack pointer never passes the stack depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // A push only happens with room left on the stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_PUSH) |-> (top_r < TW'(STACK_DEPTH)))
    else $error("push into a full stack");

  // The gather count stays within the child buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_GATHER) |-> (cnt_r <= CW'(MAX_CHILDREN)))
    else $error("child count beyond buffer size");

endmodule

`default_nettype wire
